[rtl/core/alr_pkg.sv]
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the antialiased line rasterizer
// Coordinate and error widths, line kinds, register indexes, sequencer
// states and the structs between the sequencer and the divider.
// ----------------------------------------------------------------------------
package alr_pkg;

	localparam int COORD_BITS = 12;
	localparam int STEP_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS   = 16;
	localparam int CNT_BITS   = $clog2(ERR_BITS);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [STEP_BITS-1:0]  steps_t;
	typedef logic [ERR_BITS-1:0]   err_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [1:0] CFG_BASE_COLOR     = 2'd0;
	localparam logic [1:0] CFG_NUM_LEVELS     = 2'd1;
	localparam logic [1:0] CFG_INTENSITY_BITS = 2'd2;

	typedef enum logic [2:0] {
		KIND_HORIZ  = 3'd0,
		KIND_VERT   = 3'd1,
		KIND_DIAG   = 3'd2,
		KIND_YMAJOR = 3'd3,
		KIND_XMAJOR = 3'd4
	} line_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_SECOND
	} seq_state_t;

	typedef struct packed {
		logic   start;
		coord_t num;
		coord_t den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		err_t quot;
	} div_rsp_t;

	typedef struct packed {
		logic [7:0] base_color;
		logic [8:0] num_levels;
		logic [3:0] intensity_bits;
	} cfg_t;

endpackage

[rtl/core/alr_div.sv]
// ----------------------------------------------------------------------------
// alr_div: iterative fractional divider
// Computes (num << 16) / den for num < den, one quotient bit per cycle with
// a single shared subtract and compare.
// ----------------------------------------------------------------------------
module alr_div
	import alr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	coord_t              rem_q;
	coord_t              den_q;
	err_t                quot_q;

	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS+1:0] diff;
	logic                  ge;

	// The remainder stays below den, so the doubled value fits one extra bit.
	assign trial = {rem_q, 1'b0};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[COORD_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(ERR_BITS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(ERR_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			quot_q <= {quot_q[ERR_BITS-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

endmodule

[rtl/core/alr_shade.sv]
// ----------------------------------------------------------------------------
// alr_shade: pixel weighting
// Takes the top accumulator bits as the weight and forms the saturated
// colors of the weighted pixel and of its complement-weighted neighbor.
// ----------------------------------------------------------------------------
module alr_shade
	import alr_pkg::*;
(
	input  err_t       acc,
	input  cfg_t       cfg,
	output logic [8:0] color_main,
	output logic [8:0] color_comp
);

	logic [4:0]          shamt;
	err_t                wt;
	logic [8:0]          mask;
	logic [ERR_BITS:0]   sum_main;
	logic [ERR_BITS:0]   sum_comp;

	// A shift of sixteen leaves no bits, so zero intensity bits weigh zero.
	assign shamt    = 5'(ERR_BITS) - {1'b0, cfg.intensity_bits};
	assign wt       = acc >> shamt;
	assign mask     = cfg.num_levels - 9'd1;
	assign sum_main = (ERR_BITS+1)'(cfg.base_color) + {1'b0, wt};
	assign sum_comp = (ERR_BITS+1)'(cfg.base_color)
		+ {1'b0, wt ^ {{(ERR_BITS-9){1'b0}}, mask}};

	assign color_main = (|sum_main[ERR_BITS:9]) ? 9'h1FF : sum_main[8:0];
	assign color_comp = (|sum_comp[ERR_BITS:9]) ? 9'h1FF : sum_comp[8:0];

endmodule

[rtl/core/antialiased_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: antialiased line stepping engine
// Walks one line between two endpoints pixel by pixel, with weighted
// neighbor pairs for lines that are neither straight nor diagonal.
// ----------------------------------------------------------------------------
// Usage: a start transfer (op = 0) loads two endpoints and returns the upper
// endpoint as its one result. Each step transfer (op = 1) advances the active
// line and returns one pixel, or two for x-major and y-major lines (the
// weighted pixel, then its complement neighbor, last set on the second). The
// final pixel of a line comes alone, with line_end. A step with no active line
// returns nothing. Configuration writes on the cfg channel are always taken.
// Timing: a start of a straight or diagonal line and every single-result
// step leave the sequencer idle; a two-result step holds the input until
// its neighbor pixel moves into the single output register. A start of an
// x-major or y-major line holds the input in S_DIV while the shared divider
// produces the 16-bit error step one quotient bit per cycle. A transfer's
// first result appears on the cycle after it. A stalled receiver holds the
// output register, and no input is taken until that register can move.
// Reset clears the line state, the output valid and the registers to their
// defaults (num_levels 256, intensity_bits 8); no line is active afterwards.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer
	import alr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  coord_t     start_x,
	input  coord_t     start_y,
	input  coord_t     stop_x,
	input  coord_t     stop_y,
	output logic       out_valid,
	input  logic       out_ready,
	output coord_t     pix_x,
	output coord_t     pix_y,
	output logic [8:0] pixel_color,
	output logic       line_end,
	output logic       last
);

	seq_state_t state_q, state_d;
	cfg_t       cfg_q;

	coord_t     cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic       xneg_q;
	steps_t     steps_q;
	err_t       acc_q, inc_q;
	line_kind_t kind_q;
	logic       active_q;

	logic       out_valid_q;
	coord_t     out_x_q, out_y_q;
	logic [8:0] out_color_q;
	logic       out_end_q, out_last_q;

	coord_t     pend_x_q, pend_y_q;
	logic [8:0] pend_color_q;

	div_req_t   div_req;
	div_rsp_t   div_rsp;

	logic out_free, in_fire, is_start, is_step, major_q;

	// Start ordering and classification.
	logic       s_swap, s_xneg, s_major_kind;
	coord_t     s_x0, s_y0, s_x1, s_y1, s_dx, s_dy;
	line_kind_t s_kind;
	coord_t     s_steps, s_minor;

	// Step arithmetic.
	err_t       acc_sum;
	logic       acc_wrap;
	coord_t     xs, yi, m_x, m_y, p_x, p_y, n_x, n_y;
	steps_t     steps_dec;
	logic [8:0] color_main, color_comp;

	// Output register load.
	logic       ld_out, ld_end, ld_last;
	coord_t     ld_x, ld_y;
	logic [8:0] ld_color;

	function automatic coord_t step_x(input coord_t x, input logic neg);
		step_x = neg ? x - 1'b1 : x + 1'b1;
	endfunction

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign is_start  = in_fire && (op == OP_START);
	assign is_step   = in_fire && (op == OP_STEP) && active_q;
	assign major_q   = (kind_q == KIND_YMAJOR) || (kind_q == KIND_XMAJOR);

	always_comb begin
		s_swap = start_y > stop_y;
		s_x0   = s_swap ? stop_x : start_x;
		s_y0   = s_swap ? stop_y : start_y;
		s_x1   = s_swap ? start_x : stop_x;
		s_y1   = s_swap ? start_y : stop_y;
		s_xneg = s_x1 < s_x0;
		s_dx   = s_xneg ? s_x0 - s_x1 : s_x1 - s_x0;
		s_dy   = s_y1 - s_y0;
		priority if (s_dy == '0) begin
			s_kind  = KIND_HORIZ;
			s_steps = s_dx;
			s_minor = s_dy;
		end else if (s_dx == '0) begin
			s_kind  = KIND_VERT;
			s_steps = s_dy;
			s_minor = s_dx;
		end else if (s_dx == s_dy) begin
			s_kind  = KIND_DIAG;
			s_steps = s_dy;
			s_minor = s_dx;
		end else if (s_dy > s_dx) begin
			s_kind  = KIND_YMAJOR;
			s_steps = s_dy;
			s_minor = s_dx;
		end else begin
			s_kind  = KIND_XMAJOR;
			s_steps = s_dx;
			s_minor = s_dy;
		end
		s_major_kind = (s_kind == KIND_YMAJOR) || (s_kind == KIND_XMAJOR);
	end

	always_comb begin
		acc_sum   = acc_q + inc_q;
		acc_wrap  = acc_sum <= acc_q;
		xs        = step_x(cur_x_q, xneg_q);
		yi        = cur_y_q + 1'b1;
		steps_dec = steps_q - 1'b1;
		if (kind_q == KIND_YMAJOR) begin
			m_x = acc_wrap ? xs : cur_x_q;
			m_y = yi;
			p_x = step_x(m_x, xneg_q);
			p_y = m_y;
		end else begin
			m_x = xs;
			m_y = acc_wrap ? yi : cur_y_q;
			p_x = m_x;
			p_y = m_y + 1'b1;
		end
		n_x = (kind_q != KIND_VERT) ? xs : cur_x_q;
		n_y = (kind_q != KIND_HORIZ) ? yi : cur_y_q;
	end

	alr_shade u_shade (
		.acc        (acc_sum),
		.cfg        (cfg_q),
		.color_main (color_main),
		.color_comp (color_comp)
	);

	alr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (is_start && s_major_kind) begin
					state_d = S_DIV;
				end else if (is_step && major_q && steps_q > steps_t'(1)) begin
					state_d = S_SECOND;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_IDLE;
				end
			end
			S_SECOND: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready      = (state_q == S_IDLE) && out_free;
		div_req.start = is_start && s_major_kind;
		div_req.num   = s_minor;
		div_req.den   = s_steps;
	end

	// Output register source, in order of precedence.
	always_comb begin
		ld_out   = 1'b1;
		ld_x     = pend_x_q;
		ld_y     = pend_y_q;
		ld_color = pend_color_q;
		ld_end   = 1'b0;
		ld_last  = 1'b1;
		priority if (state_q == S_SECOND) begin
			ld_out = out_free;
		end else if (is_start) begin
			ld_x     = s_x0;
			ld_y     = s_y0;
			ld_color = {1'b0, cfg_q.base_color};
			ld_end   = (s_steps == '0);
		end else if (is_step && major_q && steps_q <= steps_t'(1)) begin
			ld_x     = end_x_q;
			ld_y     = end_y_q;
			ld_color = {1'b0, cfg_q.base_color};
			ld_end   = 1'b1;
		end else if (is_step && major_q) begin
			ld_x     = m_x;
			ld_y     = m_y;
			ld_color = color_main;
			ld_last  = 1'b0;
		end else if (is_step) begin
			ld_x     = n_x;
			ld_y     = n_y;
			ld_color = {1'b0, cfg_q.base_color};
			ld_end   = (steps_dec == '0);
		end else begin
			ld_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= '{base_color: 8'd0, num_levels: 9'd256, intensity_bits: 4'd8};
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			xneg_q      <= 1'b0;
			steps_q     <= '0;
			acc_q       <= '0;
			inc_q       <= '0;
			kind_q      <= KIND_HORIZ;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BASE_COLOR:     cfg_q.base_color     <= cfg_data[7:0];
					CFG_NUM_LEVELS:     cfg_q.num_levels     <= cfg_data;
					CFG_INTENSITY_BITS: cfg_q.intensity_bits <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == S_DIV && div_rsp.done) begin
				inc_q <= div_rsp.quot;
			end

			if (is_start) begin
				cur_x_q  <= s_x0;
				cur_y_q  <= s_y0;
				end_x_q  <= s_x1;
				end_y_q  <= s_y1;
				xneg_q   <= s_xneg;
				steps_q  <= {1'b0, s_steps};
				acc_q    <= '0;
				inc_q    <= '0;
				kind_q   <= s_kind;
				active_q <= (s_steps != '0);
			end else if (is_step && major_q && steps_q <= steps_t'(1)) begin
				steps_q  <= '0;
				active_q <= 1'b0;
				cur_x_q  <= end_x_q;
				cur_y_q  <= end_y_q;
			end else if (is_step && major_q) begin
				acc_q   <= acc_sum;
				cur_x_q <= m_x;
				cur_y_q <= m_y;
				steps_q <= steps_dec;
			end else if (is_step) begin
				cur_x_q <= n_x;
				cur_y_q <= n_y;
				steps_q <= steps_dec;
				if (steps_dec == '0) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_x_q     <= ld_x;
			out_y_q     <= ld_y;
			out_color_q <= ld_color;
			out_end_q   <= ld_end;
			out_last_q  <= ld_last;
		end
		if (is_step && major_q) begin
			pend_x_q     <= p_x;
			pend_y_q     <= p_y;
			pend_color_q <= color_comp;
		end
	end

	assign out_valid   = out_valid_q;
	assign pix_x       = out_x_q;
	assign pix_y       = out_y_q;
	assign pixel_color = out_color_q;
	assign line_end    = out_end_q;
	assign last        = out_last_q;

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SECOND |-> out_valid_q)
		else $error("neighbor pixel pending without the weighted pixel");
	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> steps_q != '0)
		else $error("active line with no steps left");
	a_increment_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIV && active_q && major_q) |-> inc_q != '0)
		else $error("weighted line stepping without an error step");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == S_DIV)
		else $error("divider running outside the division state");

endmodule

[tb/antialiased_line_rasterizer_tb.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_tb: self-checking bench of the line rasterizer
// Drives start and step transfers with bursty timing against a stalling
// receiver, predicts every pixel from a behavioral copy of the line walker,
// and compares each received pixel in order. Runs through several register
// settings, the extremes and out-of-range values among them.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_tb
	import alr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 1000;
	localparam int SETTLE_TIME  = 24;
	localparam int MAX_REPORTS  = 10;
	localparam int RX_FREE      = 0;
	localparam int RX_JITTER    = 1;
	localparam int RX_LONG_HOLD = 2;

	typedef struct packed {
		coord_t     x;
		coord_t     y;
		logic [8:0] color;
		logic       line_done;
		logic       item_done;
	} pixel_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       op;
	coord_t     start_x;
	coord_t     start_y;
	coord_t     stop_x;
	coord_t     stop_y;
	logic       out_valid;
	logic       out_ready;
	coord_t     pix_x;
	coord_t     pix_y;
	logic [8:0] pixel_color;
	logic       line_end;
	logic       last;

	// Predicted line walker state and register copies.
	coord_t     ln_x, ln_y, ln_end_x, ln_end_y;
	logic       ln_x_neg;
	steps_t     ln_steps;
	err_t       ln_acc, ln_inc;
	line_kind_t ln_kind;
	logic       ln_active;
	logic [7:0] reg_base;
	logic [8:0] reg_levels;
	logic [3:0] reg_ibits;

	pixel_t pixel_q[$];

	int errors         = 0;
	int pixels_checked = 0;
	int lines_started  = 0;
	int steps_sent     = 0;
	int reg_writes     = 0;
	int busy_items     = 0;
	int burst_left     = 0;
	int idle_cycles    = 0;

	antialiased_line_rasterizer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.start_x     (start_x),
		.start_y     (start_y),
		.stop_x      (stop_x),
		.stop_y      (stop_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.pixel_color (pixel_color),
		.line_end    (line_end),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [8:0] clamp_color(input int unsigned c);
		return (c > 32'd511) ? 9'd511 : c[8:0];
	endfunction

	function automatic coord_t next_col(input coord_t x);
		return ln_x_neg ? x - 12'd1 : x + 12'd1;
	endfunction

	// Updates the predicted walker for one accepted transfer and queues the
	// pixels it must produce; n returns how many.
	task automatic rasterize_item(input logic op_i, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, output int n);
		coord_t      x0, y0, x1, y1, tmp;
		int unsigned dx, dy, wt, lvl_mask;
		err_t        prev;
		n = 0;
		if (op_i == OP_START) begin
			x0 = sx; y0 = sy; x1 = ex; y1 = ey;
			if (y0 > y1) begin
				tmp = y0; y0 = y1; y1 = tmp;
				tmp = x0; x0 = x1; x1 = tmp;
			end
			ln_x = x0; ln_y = y0; ln_end_x = x1; ln_end_y = y1;
			ln_acc = '0;
			ln_inc = '0;
			ln_x_neg = (x1 < x0);
			dx = ln_x_neg ? x0 - x1 : x1 - x0;
			dy = y1 - y0;
			if (dy == 0) begin
				ln_kind = KIND_HORIZ; ln_steps = steps_t'(dx);
			end else if (dx == 0) begin
				ln_kind = KIND_VERT; ln_steps = steps_t'(dy);
			end else if (dx == dy) begin
				ln_kind = KIND_DIAG; ln_steps = steps_t'(dy);
			end else if (dy > dx) begin
				ln_kind = KIND_YMAJOR; ln_steps = steps_t'(dy);
				ln_inc = err_t'((dx << ERR_BITS) / dy);
			end else begin
				ln_kind = KIND_XMAJOR; ln_steps = steps_t'(dx);
				ln_inc = err_t'((dy << ERR_BITS) / dx);
			end
			ln_active = (ln_steps != 0);
			pixel_q.push_back(pixel_t'{x0, y0, clamp_color(reg_base), !ln_active, 1'b1});
			n = 1;
			lines_started++;
		end else if (ln_active) begin
			if (ln_kind == KIND_YMAJOR || ln_kind == KIND_XMAJOR) begin
				if (ln_steps <= 1) begin
					ln_steps = '0;
					ln_active = 1'b0;
					ln_x = ln_end_x;
					ln_y = ln_end_y;
					pixel_q.push_back(pixel_t'{ln_end_x, ln_end_y, clamp_color(reg_base),
						1'b1, 1'b1});
					n = 1;
				end else begin
					prev = ln_acc;
					ln_acc = ln_acc + ln_inc;
					// A wrap of the accumulator moves the minor axis by one.
					if (ln_kind == KIND_YMAJOR) begin
						if (ln_acc <= prev) ln_x = next_col(ln_x);
						ln_y = ln_y + 12'd1;
					end else begin
						if (ln_acc <= prev) ln_y = ln_y + 12'd1;
						ln_x = next_col(ln_x);
					end
					ln_steps = ln_steps - 13'd1;
					wt = ln_acc >> (ERR_BITS - reg_ibits);
					lvl_mask = (int'(reg_levels) - 1) & 511;
					pixel_q.push_back(pixel_t'{ln_x, ln_y, clamp_color(reg_base + wt),
						1'b0, 1'b0});
					if (ln_kind == KIND_YMAJOR)
						pixel_q.push_back(pixel_t'{next_col(ln_x), ln_y,
							clamp_color(reg_base + (wt ^ lvl_mask)), 1'b0, 1'b1});
					else
						pixel_q.push_back(pixel_t'{ln_x, ln_y + 12'd1,
							clamp_color(reg_base + (wt ^ lvl_mask)), 1'b0, 1'b1});
					n = 2;
				end
			end else begin
				if (ln_kind != KIND_VERT) ln_x = next_col(ln_x);
				if (ln_kind != KIND_HORIZ) ln_y = ln_y + 12'd1;
				ln_steps = ln_steps - 13'd1;
				if (ln_steps == 0) ln_active = 1'b0;
				pixel_q.push_back(pixel_t'{ln_x, ln_y, clamp_color(reg_base),
					!ln_active, 1'b1});
				n = 1;
			end
		end
	endtask

	task automatic send_item(input logic op_i, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		int n;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= op_i;
		start_x  <= sx;
		start_y  <= sy;
		stop_x   <= ex;
		stop_y   <= ey;
		do @(posedge clk); while (!in_ready);
		rasterize_item(op_i, sx, sy, ex, ey, n);
		if (op_i == OP_STEP) steps_sent++;
		if (n != 0) busy_items++;
	endtask

	// Endpoint fields of a step transfer are don't-care, so they carry noise.
	task automatic send_step();
		send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom));
	endtask

	task automatic draw_line(input coord_t x0, input coord_t y0, input coord_t x1,
			input coord_t y1, input int max_steps);
		int sent;
		sent = 0;
		send_item(OP_START, x0, y0, x1, y1);
		while (ln_active && sent < max_steps) begin
			send_step();
			sent++;
		end
	endtask

	// Steps that hit no active line leave nothing queued, so the block gets
	// a settle time on top of the drained queue.
	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[8:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BASE_COLOR:     reg_base   = value[7:0];
			CFG_NUM_LEVELS:     reg_levels = value[8:0];
			CFG_INTENSITY_BITS: reg_ibits  = value[3:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(input int unsigned base, input int unsigned levels,
			input int unsigned ibits);
		go_idle();
		write_reg(CFG_BASE_COLOR, base);
		write_reg(CFG_NUM_LEVELS, levels);
		write_reg(CFG_INTENSITY_BITS, ibits);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t edge_biased_coord();
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (pick == 0) return coord_t'($urandom_range(0, 3));
		if (pick == 1) return coord_t'($urandom_range(4092, 4095));
		return coord_t'($urandom);
	endfunction

	function automatic coord_t shift_coord(input coord_t a, input int unsigned d);
		if ($urandom_range(0, 1) == 1 && int'(a) >= int'(d)) return a - coord_t'(d);
		if (int'(a) + int'(d) <= 4095) return a + coord_t'(d);
		return a - coord_t'(d);
	endfunction

	task automatic test_straight_lines();
		send_step();
		draw_line(12'd0, 12'd0, 12'd0, 12'd0, 0);
		draw_line(12'd20, 12'd7, 12'd18, 12'd7, 2);
		draw_line(12'd5, 12'd9, 12'd5, 12'd8, 1);
		draw_line(12'd4095, 12'd4095, 12'd4093, 12'd4093, 2);
		send_step();
	endtask

	task automatic test_major_lines();
		draw_line(12'd4095, 12'd4090, 12'd4093, 12'd4095, 5);
		draw_line(12'd0, 12'd4094, 12'd3, 12'd4095, 3);
		// Left active on purpose: the next start must drop it.
		draw_line(12'd4095, 12'd0, 12'd0, 12'd100, 2);
	endtask

	task automatic test_register_extremes();
		// Wide weighting with a full mask drives the color into saturation.
		set_config(255, 0, 15);
		draw_line(12'd100, 12'd100, 12'd103, 12'd110, 2);
		// Registers change between steps of the same line.
		set_config(7, 2, 0);
		send_step();
		send_step();
	endtask

	task automatic random_line_group();
		coord_t      x0, y0, x1, y1;
		int unsigned sel, dx, dy, cap;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			send_step();
		end else if (sel < 20) begin
			draw_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), $urandom_range(0, 3));
		end else begin
			x0 = edge_biased_coord();
			y0 = edge_biased_coord();
			if (sel < 32) begin
				dx = $urandom_range(1, 24); dy = 0;
			end else if (sel < 44) begin
				dx = 0; dy = $urandom_range(1, 24);
			end else if (sel < 56) begin
				dx = $urandom_range(1, 24); dy = dx;
			end else if (sel < 78) begin
				dy = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(2, 24);
				dx = $urandom_range(1, dy - 1);
			end else begin
				dx = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(2, 24);
				dy = $urandom_range(1, dx - 1);
			end
			x1 = shift_coord(x0, dx);
			y1 = shift_coord(y0, dy);
			cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, dx + dy) : 64;
			if ($urandom_range(0, 1) == 1)
				draw_line(x1, y1, x0, y0, cap);
			else
				draw_line(x0, y0, x1, y1, cap);
			if ($urandom_range(0, 4) == 0) send_step();
		end
	endtask

	task automatic test_random_lines();
		int phase_goal;
		for (int p = 0; p < 8; p++) begin
			case (p)
				1: set_config(0, 2, 1);
				2: set_config(255, 256, 8);
				3: set_config($urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 15));
				default: set_config($urandom_range(0, 255), $urandom_range(2, 256),
					$urandom_range(1, 8));
			endcase
			phase_goal = busy_items + 100;
			while (busy_items < phase_goal) random_line_group();
		end
	endtask

	// Receiver: switches between free running, short jitter and long holds.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(RX_FREE, RX_LONG_HOLD);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (mode == RX_JITTER && $urandom_range(0, 3) == 0)
					hold_left = $urandom_range(1, 3);
				else if (mode == RX_LONG_HOLD && $urandom_range(0, 15) == 0)
					hold_left = $urandom_range(5, 30);
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected pixel x=%0d y=%0d color=%0d end=%0b last=%0b",
						pix_x, pix_y, pixel_color, line_end, last);
			end else begin
				want = pixel_q.pop_front();
				pixels_checked++;
				if (pix_x !== want.x || pix_y !== want.y || pixel_color !== want.color ||
						line_end !== want.line_done || last !== want.item_done) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"pixel mismatch: expected x=%0d y=%0d color=%0d end=%0b ",
							"last=%0b, got x=%0d y=%0d color=%0d end=%0b last=%0b"},
							want.x, want.y, want.color, want.line_done, want.item_done,
							pix_x, pix_y, pixel_color, line_end, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d pixels pending",
					idle_cycles, pixel_q.size());
				$display("antialiased_line_rasterizer_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE_COLOR;
		cfg_data  = '0;
		in_valid  = 1'b0;
		op        = OP_START;
		start_x   = '0;
		start_y   = '0;
		stop_x    = '0;
		stop_y    = '0;
		reg_base   = 8'd0;
		reg_levels = 9'd256;
		reg_ibits  = 4'd8;
		ln_x = '0; ln_y = '0; ln_end_x = '0; ln_end_y = '0;
		ln_x_neg = 1'b0;
		ln_steps = '0;
		ln_acc = '0;
		ln_inc = '0;
		ln_kind = KIND_HORIZ;
		ln_active = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_straight_lines();
		test_major_lines();
		test_register_extremes();
		test_random_lines();
		go_idle();

		$display("covered %0d line starts and %0d steps over %0d register writes",
			lines_started, steps_sent, reg_writes);
		$display("%0d pixels compared, %0d mismatches", pixels_checked, errors);
		if (errors == 0 && pixel_q.size() == 0)
			$display("antialiased_line_rasterizer_tb: clean");
		else
			$display("antialiased_line_rasterizer_tb: errors");
		$finish;
	end

endmodule
